// ----- rtl/core/apq_pkg.sv -----
package apq_pkg;

    // table size and derived widths
    localparam int Depth    = 16;
    localparam int IDX_W    = $clog2(Depth);
    localparam int CNT_W    = $clog2(Depth + 1);

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 16;
    localparam int PRI_W    = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_URGENT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EVICT = 2'd3;

    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [PRI_W-1:0]    pri;
        logic [POS_W-1:0]    position;
        logic [FILL_W-1:0]   fill;
    } t_result;

endpackage

// ----- rtl/core/apq_in_if.sv -----
interface apq_in_if;
    logic                         valid;
    logic                         ready;
    logic [apq_pkg::OP_W-1:0]     operation;
    logic [apq_pkg::VALUE_W-1:0]  item_value;
    logic [apq_pkg::PRI_W-1:0]    item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

// ----- rtl/core/apq_out_if.sv -----
interface apq_out_if;
    logic                          valid;
    logic                          ready;
    logic [apq_pkg::STATUS_W-1:0]  status;
    logic [apq_pkg::VALUE_W-1:0]   out_value;
    logic [apq_pkg::PRI_W-1:0]     out_priority;
    logic [apq_pkg::POS_W-1:0]     out_position;
    logic [apq_pkg::FILL_W-1:0]    fill_count;

    modport source (output valid, output status, output out_value, output out_priority,
                    output out_position, output fill_count, input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                    input out_position, input fill_count, output ready);
endinterface

// ----- rtl/core/apq_store.sv -----
module apq_store (
    input  logic              i_clk,
    input  apq_pkg::t_mem_req i_req,
    output apq_pkg::t_entry   o_rdata
);

    apq_pkg::t_entry r_mem [apq_pkg::Depth];
    apq_pkg::t_entry r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/apq_ctrl.sv -----
module apq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    apq_in_if.sink             i_in,
    output apq_pkg::t_mem_req  o_req,
    input  apq_pkg::t_entry    i_rdata,
    output logic               o_res_valid,
    output apq_pkg::t_result   o_res,
    input  logic               i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE, S_EVICT, S_WALK, S_PLACE, S_SCAN, S_SHIFT, S_FINISH
    } t_state;

    t_state                       r_state, n_state;
    logic [apq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [apq_pkg::IDX_W-1:0]    r_k, n_k;
    logic [apq_pkg::IDX_W-1:0]    r_ptr, n_ptr;
    logic [apq_pkg::IDX_W-1:0]    r_best_idx, n_best_idx;
    apq_pkg::t_entry              r_best, n_best;
    apq_pkg::t_entry              r_new, n_new;
    apq_pkg::t_result             r_res, n_res;

    logic                         full;
    logic [apq_pkg::CNT_W-1:0]    cnt_inc;
    logic                         take;
    apq_pkg::t_entry              cand;
    logic [apq_pkg::IDX_W-1:0]    cand_idx;

    assign full    = (r_count == apq_pkg::CNT_W'(apq_pkg::Depth));
    assign cnt_inc = full ? r_count : r_count + apq_pkg::CNT_W'(1);

    // running first-maximum of the scan
    assign take     = (r_ptr == '0) || (i_rdata.pri > r_best.pri);
    assign cand     = take ? i_rdata : r_best;
    assign cand_idx = take ? r_ptr : r_best_idx;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_ptr      = r_ptr;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_new      = r_new;
        n_res      = r_res;
        o_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_new.value = i_in.item_value;
                    n_new.pri   = i_in.item_priority;
                    n_res       = '0;
                    n_state     = S_FINISH;
                    case (i_in.operation)
                        apq_pkg::OP_APPEND: begin
                            if (full) begin
                                n_res.status = apq_pkg::ST_FULL;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_count[apq_pkg::IDX_W-1:0];
                                o_req.wdata = n_new;
                                n_count     = cnt_inc;
                            end
                        end
                        apq_pkg::OP_URGENT: begin
                            if (full) begin
                                n_k         = apq_pkg::IDX_W'(apq_pkg::Depth - 1);
                                o_req.raddr = apq_pkg::IDX_W'(apq_pkg::Depth - 1);
                                n_state     = S_EVICT;
                            end else if (r_count == '0) begin
                                o_req.we    = 1'b1;
                                o_req.waddr = '0;
                                o_req.wdata = n_new;
                                n_count     = cnt_inc;
                            end else begin
                                n_k         = r_count[apq_pkg::IDX_W-1:0];
                                o_req.raddr = r_count[apq_pkg::IDX_W-1:0]
                                              - apq_pkg::IDX_W'(1);
                                n_state     = S_WALK;
                            end
                        end
                        apq_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = apq_pkg::ST_EMPTY;
                            end else begin
                                o_req.raddr = '0;
                                n_ptr       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.fill = apq_pkg::FILL_W'(n_count);
                end
            end
            S_EVICT: begin
                // tail entry arrives; report it and start the walk one below
                n_res.status   = apq_pkg::ST_EVICT;
                n_res.value    = i_rdata.value;
                n_res.pri      = i_rdata.pri;
                n_res.position = apq_pkg::POS_W'(apq_pkg::Depth - 1);
                o_req.raddr    = apq_pkg::IDX_W'(apq_pkg::Depth - 2);
                n_state        = S_WALK;
            end
            S_WALK: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_k;
                if (i_rdata.pri < r_new.pri) begin
                    o_req.wdata = i_rdata;
                    n_k         = r_k - apq_pkg::IDX_W'(1);
                    if (r_k == apq_pkg::IDX_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        o_req.raddr = r_k - apq_pkg::IDX_W'(2);
                    end
                end else begin
                    o_req.wdata = r_new;
                    n_count     = cnt_inc;
                    n_res.fill  = apq_pkg::FILL_W'(cnt_inc);
                    n_state     = S_FINISH;
                end
            end
            S_PLACE: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_k;
                o_req.wdata = r_new;
                n_count     = cnt_inc;
                n_res.fill  = apq_pkg::FILL_W'(cnt_inc);
                n_state     = S_FINISH;
            end
            S_SCAN: begin
                n_best     = cand;
                n_best_idx = cand_idx;
                if ((apq_pkg::CNT_W'(r_ptr) + apq_pkg::CNT_W'(1)) < r_count) begin
                    o_req.raddr = r_ptr + apq_pkg::IDX_W'(1);
                    n_ptr       = r_ptr + apq_pkg::IDX_W'(1);
                end else begin
                    n_res.status   = apq_pkg::ST_OK;
                    n_res.value    = cand.value;
                    n_res.pri      = cand.pri;
                    n_res.position = apq_pkg::POS_W'(cand_idx);
                    n_ptr          = cand_idx;
                    if ((apq_pkg::CNT_W'(cand_idx) + apq_pkg::CNT_W'(1)) < r_count) begin
                        o_req.raddr = cand_idx + apq_pkg::IDX_W'(1);
                        n_state     = S_SHIFT;
                    end else begin
                        n_count    = r_count - apq_pkg::CNT_W'(1);
                        n_res.fill = apq_pkg::FILL_W'(r_count - apq_pkg::CNT_W'(1));
                        n_state    = S_FINISH;
                    end
                end
            end
            S_SHIFT: begin
                // close the gap: entry ptr+1 moves down to ptr
                o_req.we    = 1'b1;
                o_req.waddr = r_ptr;
                o_req.wdata = i_rdata;
                n_ptr       = r_ptr + apq_pkg::IDX_W'(1);
                if ((apq_pkg::CNT_W'(r_ptr) + apq_pkg::CNT_W'(2)) < r_count) begin
                    o_req.raddr = r_ptr + apq_pkg::IDX_W'(2);
                end else begin
                    n_count    = r_count - apq_pkg::CNT_W'(1);
                    n_res.fill = apq_pkg::FILL_W'(r_count - apq_pkg::CNT_W'(1));
                    n_state    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_k        <= n_k;
        r_ptr      <= n_ptr;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_new      <= n_new;
        r_res      <= n_res;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FINISH);
    assign o_res       = r_res;

endmodule

// ----- rtl/core/array_priority_queue.sv -----
// Channel   Dir   Interface    Payload
// i_in      in    apq_in_if    operation, item_value, item_priority
// o_out     out   apq_out_if   status, out_value, out_priority, out_position, fill_count
//
// One transaction in gives one transaction out. The sequencer is busy from the accept
// cycle to the hand-off into the output register. Append, rejected append, remove on
// empty and the unused code go from accept straight to that hand-off. Urgent insert
// writes straight into an empty table; else it walks lower-priority entries up one slot
// per step, then places the item, and when full it first reads the tail for eviction.
// Remove scans all entries, then moves down the entries above the removed slot. Every
// step is one access of the single-read, single-write table memory with its registered read.
// Reset clears the fill count and handshake state; table contents are not cleared.
// The output register frees the sequencer, so it takes a new transaction while a
// result is still waiting on o_out; a stalled o_out holds the sequencer at its end.
module array_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apq_in_if.sink     i_in,
    apq_out_if.source  o_out
);

    apq_pkg::t_mem_req  mem_req;
    apq_pkg::t_entry    mem_rdata;
    logic               res_valid;
    logic               res_ready;
    apq_pkg::t_result   res;

    logic               r_out_valid;
    apq_pkg::t_result   r_out;

    // table memory: {priority, value} per slot
    apq_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // sequencer: append, sorted walk, scan and gap closing
    apq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_req       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register: loads when empty or being drained this cycle
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.out_value    = r_out.value;
    assign o_out.out_priority = r_out.pri;
    assign o_out.out_position = r_out.position;
    assign o_out.fill_count   = r_out.fill;

endmodule
